[src/sorted_name_table_search_assert.svh]
// ----------------------------------------------------------------------------
// sorted name table search assertion macros
// concurrent check helpers used by sorted_name_table_search
// ----------------------------------------------------------------------------
`ifndef SORTED_NAME_TABLE_SEARCH_ASSERT_SVH
`define SORTED_NAME_TABLE_SEARCH_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define SNTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on clk, quiet in reset
`define SNTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/snts_pkg.sv]
// ----------------------------------------------------------------------------
// snts_pkg
// shared types, codes and defaults of the sorted name table search block
// ----------------------------------------------------------------------------
package snts_pkg;

    localparam int MAX_ENTRIES_DEF = 128;
    localparam int KEY_WORDS_DEF   = 7;

    localparam int REQ_W    = 2;
    localparam int CHUNK_W  = 64;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 7;

    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STS_CLEARED   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD,
        S_SA_RD,
        S_SA_CAP,
        S_SB_RD,
        S_SB_CAP,
        S_WR,
        S_WRL,
        S_BS_CHK,
        S_BS_RD,
        S_BS_CAP
    } state_t;

    // word compare outcome: decided on a differing byte or a shared terminator
    typedef struct packed {
        logic decided;
        logic less;
        logic greater;
    } cmp_t;

endpackage

[src/snts_cmp.sv]
// ----------------------------------------------------------------------------
// snts_cmp
// strcmp-style compare of one 64-bit key word, first character in msb
// ----------------------------------------------------------------------------
module snts_cmp (
    input  logic [snts_pkg::CHUNK_W-1:0] a,
    input  logic [snts_pkg::CHUNK_W-1:0] b,
    output snts_pkg::cmp_t               res
);
    import snts_pkg::*;

    always_comb
    begin
        logic [7:0] ca;
        logic [7:0] cb;
        res = '0;
        for (int k = 7; k >= 0; k--)
        begin
            ca = a[k*8 +: 8];
            cb = b[k*8 +: 8];
            if (!res.decided)
            begin
                if (ca != cb)
                begin
                    res.decided = 1'b1;
                    res.less    = (ca < cb);
                    res.greater = (ca > cb);
                end
                else if (ca == 8'd0)
                begin
                    res.decided = 1'b1;
                end
            end
        end
    end

endmodule

[src/sorted_name_table_search.sv]
// ----------------------------------------------------------------------------
// sorted_name_table_search
// key table with append, clear, bubble sort on demand and binary search
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------
//  request   | start, busy            | req_type, chunk, chunk_last
//  result    | done (one-cycle beat)  | status, index
//
//  a chunk that is not the last is taken without leaving idle; clear and
//  full-drop beats finish in idle; a store pads the rest of its slot, one
//  word a cycle; search: at most log2(n)+1 probes, each reading the probe key
//  word by word through the one read port and the one shared word comparator
//  an unsorted table of two or more keys is first bubble-sorted in memory
//  reset is async active low; the key memory is not cleared
//  the receiver cannot stall: results are one-cycle strobes on done
// ----------------------------------------------------------------------------
`include "sorted_name_table_search_assert.svh"

module sorted_name_table_search #(
    parameter int MAX_ENTRIES = snts_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_WORDS   = snts_pkg::KEY_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [snts_pkg::REQ_W-1:0]    req_type,
    input  logic [snts_pkg::CHUNK_W-1:0]  chunk,
    input  logic                          chunk_last,
    output logic                          done,
    output logic [snts_pkg::STATUS_W-1:0] status,
    output logic [snts_pkg::INDEX_W-1:0]  index
);
    import snts_pkg::*;

    localparam int DEPTH  = MAX_ENTRIES * KEY_WORDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W  = $clog2(KEY_WORDS + 1);
    localparam int WIDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int BS_W   = CNT_W + 1;

    // slot base plus word offset
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [WIDX_W-1:0] w);
        return ADDR_W'(s) * ADDR_W'(KEY_WORDS) + ADDR_W'(w);
    endfunction

    // control state
    state_t               state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 sorted_reg, sorted_next;
    logic [POS_W-1:0]     w_reg, w_next;
    logic [SLOT_W-1:0]    j_reg, j_next;
    logic [SLOT_W-1:0]    plen_reg, plen_next;
    logic                 carry_reg, carry_next;
    logic signed [BS_W-1:0] lo_reg, lo_next;
    logic signed [BS_W-1:0] hi_reg, hi_next;
    logic [SLOT_W-1:0]    mid_reg, mid_next;
    logic                 cmp_done_reg, cmp_done_next;
    logic                 cmp_lt_reg, cmp_lt_next;
    logic                 cmp_gt_reg, cmp_gt_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [CHUNK_W-1:0]   skey_reg [KEY_WORDS];
    logic [CHUNK_W-1:0]   skey_next [KEY_WORDS];

    // payload state
    logic [CHUNK_W-1:0]   kbuf_reg [2][KEY_WORDS];
    logic [CHUNK_W-1:0]   kbuf_next [2][KEY_WORDS];

    // key memory
    logic [CHUNK_W-1:0]   mem [DEPTH];
    logic [CHUNK_W-1:0]   mem_q;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [CHUNK_W-1:0]   mem_wdata;

    // shared comparator
    logic [CHUNK_W-1:0]   cmp_a;
    logic [CHUNK_W-1:0]   cmp_b;
    cmp_t                 cmp_res;

    logic                 accept;
    logic                 full;
    logic                 pos_room;
    logic [POS_W-1:0]     pos_inc;
    logic                 pad_needed;
    logic                 need_sort;
    logic                 w_last;
    logic [WIDX_W-1:0]    widx;
    logic [WIDX_W-1:0]    pidx;
    logic                 fin_lt;
    logic                 fin_gt;
    logic                 decided_now;
    logic signed [BS_W-1:0] mid_calc;
    logic signed [BS_W-1:0] mid_s;
    logic signed [BS_W-1:0] last_slot;
    logic                 bs_open;

    assign accept     = start && (state_reg == S_IDLE);
    assign full       = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign pos_room   = (pos_reg < POS_W'(KEY_WORDS));
    assign pos_inc    = pos_room ? (pos_reg + POS_W'(1)) : pos_reg;
    assign pad_needed = (pos_inc < POS_W'(KEY_WORDS));
    assign need_sort  = !sorted_reg && (count_reg >= CNT_W'(2));
    assign w_last     = (w_reg == POS_W'(KEY_WORDS - 1));
    assign widx       = w_reg[WIDX_W-1:0];
    assign pidx       = pos_reg[WIDX_W-1:0];
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign mid_s      = $signed(BS_W'(mid_reg));
    assign last_slot  = $signed(BS_W'(count_reg)) - BS_W'(1);
    assign bs_open    = (lo_reg <= hi_reg);

    // sort compares carried key against the next slot, search compares probe
    // against the search key
    assign cmp_a = (state_reg == S_SB_CAP) ? kbuf_reg[carry_reg][widx] : mem_q;
    assign cmp_b = (state_reg == S_SB_CAP) ? mem_q : skey_reg[widx];

    snts_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // first deciding word wins
    assign fin_lt      = cmp_done_reg ? cmp_lt_reg : cmp_res.less;
    assign fin_gt      = cmp_done_reg ? cmp_gt_reg : cmp_res.greater;
    assign decided_now = cmp_done_reg || cmp_res.decided;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && chunk_last)
                begin
                    case (req_type)
                        REQ_STORE:
                        begin
                            if (!full && pad_needed)
                            begin
                                state_next = S_PAD;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            state_next = need_sort ? S_SA_RD : S_BS_CHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                if (w_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SA_RD:
            begin
                state_next = S_SA_CAP;
            end
            S_SA_CAP:
            begin
                state_next = w_last ? S_SB_RD : S_SA_RD;
            end
            S_SB_RD:
            begin
                state_next = S_SB_CAP;
            end
            S_SB_CAP:
            begin
                state_next = w_last ? S_WR : S_SB_RD;
            end
            S_WR:
            begin
                if (w_last)
                begin
                    state_next = ((j_reg + SLOT_W'(1)) == plen_reg) ? S_WRL : S_SB_RD;
                end
            end
            S_WRL:
            begin
                if (w_last)
                begin
                    state_next = (plen_reg == SLOT_W'(1)) ? S_BS_CHK : S_SA_RD;
                end
            end
            S_BS_CHK:
            begin
                state_next = bs_open ? S_BS_RD : S_IDLE;
            end
            S_BS_RD:
            begin
                state_next = S_BS_CAP;
            end
            S_BS_CAP:
            begin
                if (decided_now || w_last)
                begin
                    state_next = (!fin_lt && !fin_gt) ? S_IDLE : S_BS_CHK;
                end
                else
                begin
                    state_next = S_BS_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory controls and result beat
    always_comb
    begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        sorted_next   = sorted_reg;
        w_next        = w_reg;
        j_next        = j_reg;
        plen_next     = plen_reg;
        carry_next    = carry_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        cmp_done_next = cmp_done_reg;
        cmp_lt_next   = cmp_lt_reg;
        cmp_gt_next   = cmp_gt_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        index_next    = index_reg;
        skey_next     = skey_reg;
        kbuf_next     = kbuf_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_STORE:
                        begin
                            if (full)
                            begin
                                // chunks still advance the position, then drop
                                pos_next = chunk_last ? '0 : pos_inc;
                                if (chunk_last)
                                begin
                                    done_next   = 1'b1;
                                    status_next = STS_FULL;
                                    index_next  = '0;
                                end
                            end
                            else
                            begin
                                if (pos_room)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = slot_addr(count_reg[SLOT_W-1:0], pidx);
                                    mem_wdata = chunk;
                                end
                                pos_next = pos_inc;
                                if (chunk_last)
                                begin
                                    pos_next = '0;
                                    if (pad_needed)
                                    begin
                                        w_next = pos_inc;
                                    end
                                    else
                                    begin
                                        done_next   = 1'b1;
                                        status_next = STS_STORED;
                                        index_next  = INDEX_W'(count_reg);
                                        count_next  = count_reg + CNT_W'(1);
                                        sorted_next = 1'b0;
                                    end
                                end
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (pos_room)
                            begin
                                skey_next[pidx] = chunk;
                            end
                            pos_next = pos_inc;
                            if (chunk_last)
                            begin
                                // zero-pad the words after the last chunk
                                for (int k = 0; k < KEY_WORDS; k++)
                                begin
                                    if (POS_W'(k) >= pos_inc)
                                    begin
                                        skey_next[k] = '0;
                                    end
                                end
                                pos_next = '0;
                                if (need_sort)
                                begin
                                    plen_next  = SLOT_W'(count_reg - CNT_W'(1));
                                    w_next     = '0;
                                    carry_next = 1'b0;
                                end
                                else
                                begin
                                    sorted_next = 1'b1;
                                    lo_next     = '0;
                                    hi_next     = last_slot;
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next  = '0;
                            sorted_next = 1'b1;
                            pos_next    = '0;
                            done_next   = 1'b1;
                            status_next = STS_CLEARED;
                            index_next  = '0;
                        end
                        default:
                        begin
                            pos_next = pos_reg;
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_addr(count_reg[SLOT_W-1:0], widx);
                mem_wdata = '0;
                w_next    = w_reg + POS_W'(1);
                if (w_last)
                begin
                    w_next      = '0;
                    done_next   = 1'b1;
                    status_next = STS_STORED;
                    index_next  = INDEX_W'(count_reg);
                    count_next  = count_reg + CNT_W'(1);
                    sorted_next = 1'b0;
                end
            end
            S_SA_RD:
            begin
                mem_raddr = slot_addr('0, widx);
            end
            S_SA_CAP:
            begin
                kbuf_next[carry_reg][widx] = mem_q;
                w_next = w_reg + POS_W'(1);
                if (w_last)
                begin
                    w_next        = '0;
                    j_next        = '0;
                    cmp_done_next = 1'b0;
                    cmp_lt_next   = 1'b0;
                    cmp_gt_next   = 1'b0;
                end
            end
            S_SB_RD:
            begin
                mem_raddr = slot_addr(j_reg + SLOT_W'(1), widx);
            end
            S_SB_CAP:
            begin
                kbuf_next[!carry_reg][widx] = mem_q;
                cmp_done_next = decided_now;
                cmp_lt_next   = fin_lt;
                cmp_gt_next   = fin_gt;
                w_next        = w_reg + POS_W'(1);
                if (w_last)
                begin
                    w_next = '0;
                    // larger key is carried on, smaller one goes to slot j
                    carry_next = fin_gt ? carry_reg : !carry_reg;
                end
            end
            S_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_addr(j_reg, widx);
                mem_wdata = kbuf_reg[!carry_reg][widx];
                w_next    = w_reg + POS_W'(1);
                if (w_last)
                begin
                    w_next        = '0;
                    j_next        = j_reg + SLOT_W'(1);
                    cmp_done_next = 1'b0;
                    cmp_lt_next   = 1'b0;
                    cmp_gt_next   = 1'b0;
                end
            end
            S_WRL:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_addr(plen_reg, widx);
                mem_wdata = kbuf_reg[carry_reg][widx];
                w_next    = w_reg + POS_W'(1);
                if (w_last)
                begin
                    w_next = '0;
                    if (plen_reg == SLOT_W'(1))
                    begin
                        sorted_next = 1'b1;
                        lo_next     = '0;
                        hi_next     = last_slot;
                    end
                    else
                    begin
                        plen_next = plen_reg - SLOT_W'(1);
                        j_next    = '0;
                    end
                end
            end
            S_BS_CHK:
            begin
                if (bs_open)
                begin
                    mid_next      = mid_calc[SLOT_W-1:0];
                    w_next        = '0;
                    cmp_done_next = 1'b0;
                    cmp_lt_next   = 1'b0;
                    cmp_gt_next   = 1'b0;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STS_NOT_FOUND;
                    index_next  = '0;
                end
            end
            S_BS_RD:
            begin
                mem_raddr = slot_addr(mid_reg, widx);
            end
            S_BS_CAP:
            begin
                w_next = w_reg + POS_W'(1);
                if (decided_now || w_last)
                begin
                    w_next = '0;
                    if (!fin_lt && !fin_gt)
                    begin
                        done_next   = 1'b1;
                        status_next = STS_FOUND;
                        index_next  = INDEX_W'(mid_reg);
                    end
                    else if (fin_lt)
                    begin
                        lo_next = mid_s + BS_W'(1);
                    end
                    else
                    begin
                        hi_next = mid_s - BS_W'(1);
                    end
                end
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            sorted_reg   <= 1'b1;
            w_reg        <= '0;
            j_reg        <= '0;
            plen_reg     <= '0;
            carry_reg    <= 1'b0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            mid_reg      <= '0;
            cmp_done_reg <= 1'b0;
            cmp_lt_reg   <= 1'b0;
            cmp_gt_reg   <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= '0;
            index_reg    <= '0;
            for (int k = 0; k < KEY_WORDS; k++)
            begin
                skey_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            sorted_reg   <= sorted_next;
            w_reg        <= w_next;
            j_reg        <= j_next;
            plen_reg     <= plen_next;
            carry_reg    <= carry_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            mid_reg      <= mid_next;
            cmp_done_reg <= cmp_done_next;
            cmp_lt_reg   <= cmp_lt_next;
            cmp_gt_reg   <= cmp_gt_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            index_reg    <= index_next;
            skey_reg     <= skey_next;
        end
    end

    // swap buffers hold only payload
    always_ff @(posedge clk)
    begin
        kbuf_reg <= kbuf_next;
    end

    // key memory with one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign index  = index_reg;

    // checks
    `SNTS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES))
    `SNTS_ASSERT_NEXT(a_clear_beat, start && !busy && req_type == REQ_CLEAR, done && status == STS_CLEARED && index == '0)
    `SNTS_ASSERT_IMPL(a_miss_index, done && status == STS_NOT_FOUND, index == '0)
    `SNTS_ASSERT_IMPL(a_search_sorted, state_reg == S_BS_CHK || state_reg == S_BS_RD || state_reg == S_BS_CAP, sorted_reg)

endmodule

[bench/tb_sorted_name_table_search.sv]
// ----------------------------------------------------------------------------
// tb_sorted_name_table_search
// self-checking bench: queued chunk beats drive the block, a local table
// model predicts every status/index beat, the monitor compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_name_table_search;

    import snts_pkg::*;

    localparam int ENTRIES  = MAX_ENTRIES_DEF;
    localparam int KWORDS   = KEY_WORDS_DEF;
    localparam int N_ITEMS  = 1650;
    localparam int WD_LIMIT = 600000;   // idle cycles; must outlast a full-table sort

    // request code the block ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [CHUNK_W-1:0] data;
        logic               last;
    } beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] sts;
        logic [INDEX_W-1:0]  idx;
    } reply_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [REQ_W-1:0]    req_type   = '0;
    logic [CHUNK_W-1:0]  chunk      = '0;
    logic                chunk_last = 1'b0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;

    beat_t  pending_beats[$];
    reply_t expected_replies[$];
    int     accepted_beats = 0;
    int     errors         = 0;
    int     quiet_cycles   = 0;

    // local copy of the key table
    logic [CHUNK_W-1:0] table_key [ENTRIES][KWORDS];
    logic [CHUNK_W-1:0] probe_key [KWORDS];
    int                 entry_count;
    bit                 table_in_order;
    int                 word_pos;

    // stimulus-side memory of stored keys so searches can hit
    logic [CHUNK_W-1:0] gen_chunks [256][9];
    int                 gen_len [256];
    int                 gen_n     = 0;
    int                 gen_count = 0;

    sorted_name_table_search dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .chunk      (chunk),
        .chunk_last (chunk_last),
        .done       (done),
        .status     (status),
        .index      (index)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------

    // strcmp order on zero-padded keys: -1, 0, 1
    function automatic int key_order(input int row, input bit vs_probe, input int other);
        logic [7:0] ca;
        logic [7:0] cb;
        for (int w = 0; w < KWORDS; w++)
        begin
            for (int sh = 56; sh >= 0; sh -= 8)
            begin
                ca = table_key[row][w][sh +: 8];
                cb = vs_probe ? probe_key[w][sh +: 8] : table_key[other][w][sh +: 8];
                if (ca != cb)
                    return (ca < cb) ? -1 : 1;
                if (ca == 8'd0)
                    return 0;
            end
        end
        return 0;
    endfunction

    function automatic void sort_entries();
        logic [CHUNK_W-1:0] hold;
        for (int i = 0; i + 1 < entry_count; i++)
            for (int j = 0; j + 1 < entry_count - i; j++)
                if (key_order(j, 1'b0, j + 1) > 0)
                    for (int w = 0; w < KWORDS; w++)
                    begin
                        hold               = table_key[j][w];
                        table_key[j][w]    = table_key[j + 1][w];
                        table_key[j + 1][w] = hold;
                    end
        table_in_order = 1'b1;
    endfunction

    // one chunk into a store slot or the search buffer, padding on the last one
    function automatic void take_word(input bit to_probe, input logic [CHUNK_W-1:0] d,
                                      input bit last);
        if (word_pos < KWORDS)
        begin
            if (to_probe)
                probe_key[word_pos] = d;
            else
                table_key[entry_count][word_pos] = d;
            word_pos++;
        end
        if (last)
        begin
            for (int w = word_pos; w < KWORDS; w++)
                if (to_probe)
                    probe_key[w] = '0;
                else
                    table_key[entry_count][w] = '0;
            word_pos = 0;
        end
    endfunction

    function automatic void apply_beat(input beat_t b);
        int lo;
        int hi;
        int mid;
        int c;
        reply_t r;
        if (b.req == REQ_STORE)
        begin
            if (entry_count >= ENTRIES)
            begin
                // full table: chunks only move the position, last drops the key
                if (word_pos < KWORDS)
                    word_pos++;
                if (b.last)
                begin
                    word_pos = 0;
                    r.sts = STS_FULL;
                    r.idx = '0;
                    expected_replies.push_back(r);
                end
            end
            else
            begin
                take_word(1'b0, b.data, b.last);
                if (b.last)
                begin
                    r.sts = STS_STORED;
                    r.idx = INDEX_W'(entry_count);
                    expected_replies.push_back(r);
                    entry_count++;
                    table_in_order = 1'b0;
                end
            end
        end
        else if (b.req == REQ_SEARCH)
        begin
            take_word(1'b1, b.data, b.last);
            if (b.last)
            begin
                if (!table_in_order)
                    sort_entries();
                lo = 0;
                hi = entry_count - 1;
                r.sts = STS_NOT_FOUND;
                r.idx = '0;
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    c = key_order(mid, 1'b1, 0);
                    if (c == 0)
                    begin
                        r.sts = STS_FOUND;
                        r.idx = INDEX_W'(mid);
                        break;
                    end
                    if (c < 0)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                expected_replies.push_back(r);
            end
        end
        else if (b.req == REQ_CLEAR)
        begin
            entry_count    = 0;
            table_in_order = 1'b1;
            word_pos       = 0;
            r.sts = STS_CLEARED;
            r.idx = '0;
            expected_replies.push_back(r);
        end
        // the unused request type leaves everything alone
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // small alphabet so keys collide, share prefixes and end early
    function automatic logic [CHUNK_W-1:0] make_chunk();
        logic [CHUNK_W-1:0] d;
        logic [7:0] alpha [6];
        alpha = '{8'h00, 8'h61, 8'h62, 8'h63, 8'h80, 8'hff};
        if ($urandom_range(0, 4) == 0)
            return {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
            d[i*8 +: 8] = (i == 7 || $urandom_range(0, 3) != 0) ?
                          alpha[$urandom_range(1, 5)] : alpha[$urandom_range(0, 5)];
        return d;
    endfunction

    function automatic void push_beat(input logic [REQ_W-1:0] rq, input logic [CHUNK_W-1:0] d,
                                      input bit last);
        beat_t b;
        b.req  = rq;
        b.data = d;
        b.last = last;
        pending_beats.push_back(b);
    endfunction

    function automatic void push_clear();
        push_beat(REQ_CLEAR, {$urandom, $urandom}, 1'($urandom));
        gen_n     = 0;
        gen_count = 0;
    endfunction

    // store a fresh key of n chunks and remember it for later searches
    function automatic void push_store(input int n);
        logic [CHUNK_W-1:0] d;
        for (int i = 0; i < n; i++)
        begin
            d = make_chunk();
            push_beat(REQ_STORE, d, i == n - 1);
            if (gen_n < 256)
                gen_chunks[gen_n][i] = d;
        end
        if (gen_n < 256)
        begin
            gen_len[gen_n] = n;
            gen_n++;
        end
        gen_count++;
    endfunction

    function automatic void push_search_known();
        int k;
        k = $urandom_range(0, gen_n - 1);
        for (int i = 0; i < gen_len[k]; i++)
            push_beat(REQ_SEARCH, gen_chunks[k][i], i == gen_len[k] - 1);
    endfunction

    function automatic int key_len();
        int r;
        r = $urandom_range(0, 19);
        return (r < 10) ? 1 : (r < 16) ? $urandom_range(2, 3) : $urandom_range(4, 9);
    endfunction

    // ------------------------------------------------------------------
    // driver: a new beat goes out once the previous one is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int gap_pct;
        beat_t b;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                b.req  = req_type;
                b.data = chunk;
                b.last = chunk_last;
                apply_beat(b);
                accepted_beats++;
            end
            // sender gap rate by phase: light, heavy, none
            gap_pct = (accepted_beats < 550) ? 6 : (accepted_beats < 1100) ? 53 : 0;
            if (!start || !busy)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    b = pending_beats.pop_front();
                    start      <= 1'b1;
                    req_type   <= b.req;
                    chunk      <= b.data;
                    chunk_last <= b.last;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done beat must match the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected beat status %0d index %0d", $time, status, index);
                errors++;
            end
            else
            begin
                e = expected_replies.pop_front();
                if (status !== e.sts)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.sts, status);
                    errors++;
                end
                if (index !== e.idx)
                begin
                    $display("%0t: index expected %0d actual %0d", $time, e.idx, index);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int nb;
        entry_count    = 0;
        table_in_order = 1'b1;
        word_pos       = 0;
        for (int w = 0; w < KWORDS; w++)
            probe_key[w] = '0;

        // directed: empty-table search, extremes, truncation, padding
        push_beat(REQ_SEARCH, 64'h6100000000000000, 1'b1);
        push_beat(REQ_STORE, {64{1'b1}}, 1'b1);
        push_beat(REQ_STORE, '0, 1'b1);                          // empty key
        push_beat(REQ_STORE, 64'h6162630000000000, 1'b1);
        for (int i = 0; i < 9; i++)                              // cut after seven words
            push_beat(REQ_STORE, 64'h6161616161616161, i == 8);
        push_beat(REQ_SEARCH, 64'h6162630000000000, 1'b1);
        push_beat(REQ_SEARCH, '0, 1'b1);
        push_beat(REQ_SEARCH, {64{1'b1}}, 1'b1);
        push_beat(REQ_SEARCH, 64'h6162000000000000, 1'b1);       // prefix only, missing
        push_beat(REQ_UNUSED, {64{1'b1}}, 1'b1);                 // unused request
        push_beat(REQ_STORE, 64'h6200000000000000, 1'b0);        // mixed key types
        push_beat(REQ_SEARCH, 64'h6300000000000000, 1'b1);
        push_beat(REQ_CLEAR, {64{1'b1}}, 1'b0);
        push_beat(REQ_SEARCH, {64{1'b1}}, 1'b1);

        // fill to the limit with keys descending within each leading byte, then overflow and search
        push_clear();
        for (int i = 0; i < ENTRIES; i++)
            push_beat(REQ_STORE, {8'h61 + 8'(i / 64), 8'hff - 8'(i), 48'h0}, 1'b1);
        push_beat(REQ_STORE, 64'h7a00000000000000, 1'b0);
        push_beat(REQ_STORE, 64'h7a00000000000000, 1'b1);
        push_beat(REQ_STORE, '0, 1'b1);
        push_beat(REQ_SEARCH, {8'h61, 8'hff, 48'h0}, 1'b1);
        push_beat(REQ_SEARCH, {8'h62, 8'hc0, 48'h0}, 1'b1);
        push_beat(REQ_SEARCH, 64'h7a00000000000000, 1'b1);
        push_clear();

        // random: mostly well-formed store/search sequences on small tables
        while (pending_beats.size() < N_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                if (gen_count >= 10)
                    push_clear();
                push_store(key_len());
            end
            else if (r < 78)
            begin
                if (gen_n != 0 && $urandom_range(0, 9) < 7)
                    push_search_known();
                else
                begin
                    nb = key_len();
                    for (int i = 0; i < nb; i++)
                        push_beat(REQ_SEARCH, make_chunk(), i == nb - 1);
                end
            end
            else if (r < 83)
            begin
                push_clear();
            end
            else if (r < 88)
            begin
                push_beat(REQ_UNUSED, {$urandom, $urandom}, 1'($urandom));
            end
            else
            begin
                // broken key: types mixed between chunks
                nb = $urandom_range(2, 9);
                for (int i = 0; i < nb; i++)
                    push_beat($urandom_range(0, 1) ? REQ_SEARCH : REQ_STORE,
                              make_chunk(), i == nb - 1);
                gen_count++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || start)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0 && expected_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
